/* design/lav_pkg.sv */
// Shared types, constants and helper functions of the look-at view matrix pipeline.
`default_nettype none

package lav_pkg;

    // Fraction bits of a unit-vector entry (Q2.30).
    localparam int unsigned UNIT_FRAC = 30;
    // One result bit per stage in the square root and in the divider.
    localparam int unsigned SQRT_STEPS = 32;
    localparam int unsigned DIV_STEPS = UNIT_FRAC + 1;

    typedef logic [2:0][31:0] t_vec3;
    typedef logic [2:0][63:0] t_wvec3;
    typedef t_vec3 [2:0] t_rows;

    // Data that rides along with an item through the normalizers and cross products.
    typedef struct packed {
        t_vec3 eye;
        t_vec3 hup;
        t_vec3 view;
    } t_side;

    function automatic logic [63:0] f_abs64(input logic [63:0] v);
        return v[63] ? (~v + 64'd1) : v;
    endfunction

    // Magnitude of v divided by 2^UNIT_FRAC, rounded half away from zero.
    function automatic logic [63:0] f_round_mag(input logic [63:0] v);
        logic [63:0] m;
        m = f_abs64(v);
        return (m + (64'd1 << (UNIT_FRAC - 1))) >> UNIT_FRAC;
    endfunction

endpackage

`default_nettype wire

/* design/look_at_view_matrix.sv */
// Top level of the look-at view matrix pipeline: rows right, true up and view with translations.
// The pipeline takes one beat per cycle while the consumer does not stall the output. Most of
// its depth comes from the two normalizers, each with a 32-stage square root and a
// 31-stage divider that resolve one bit per stage, plus cross products and the translation.
// Reset is synchronous and active low; it clears every valid bit, payload registers keep data.
`default_nettype none

module look_at_view_matrix (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [31:0] i_eye_x,
    input  logic [31:0] i_eye_y,
    input  logic [31:0] i_eye_z,
    input  logic [31:0] i_target_x,
    input  logic [31:0] i_target_y,
    input  logic [31:0] i_target_z,
    input  logic [31:0] i_hint_up_x,
    input  logic [31:0] i_hint_up_y,
    input  logic [31:0] i_hint_up_z,
    input  logic        i_left_handed,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_right_x,
    output logic [31:0] o_right_y,
    output logic [31:0] o_right_z,
    output logic [31:0] o_right_shift,
    output logic [31:0] o_true_up_x,
    output logic [31:0] o_true_up_y,
    output logic [31:0] o_true_up_z,
    output logic [31:0] o_up_shift,
    output logic [31:0] o_view_x,
    output logic [31:0] o_view_y,
    output logic [31:0] o_view_z,
    output logic [31:0] o_view_shift
);
    // The whole pipeline moves together. It halts only while a finished beat sits in the
    // output register and the consumer stalls; every stage keeps its contents meanwhile.
    logic w_adv;
    assign w_adv   = !(o_valid && i_stall);
    assign o_stall = !w_adv;

    // Input stage: the view direction before normalization. The left-handed flag flips
    // the difference to target minus eye. Differences are widened so none can overflow.
    logic            r_a_valid;
    lav_pkg::t_wvec3 r_a_diff;
    lav_pkg::t_side  r_a_side;
    lav_pkg::t_vec3  w_eye;
    lav_pkg::t_vec3  w_tgt;
    lav_pkg::t_vec3  w_hup;
    lav_pkg::t_wvec3 n_a_diff;

    assign w_eye = {i_eye_z, i_eye_y, i_eye_x};
    assign w_tgt = {i_target_z, i_target_y, i_target_x};
    assign w_hup = {i_hint_up_z, i_hint_up_y, i_hint_up_x};

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (i_left_handed) begin
                n_a_diff[i] = 64'($signed(w_tgt[i])) - 64'($signed(w_eye[i]));
            end else begin
                n_a_diff[i] = 64'($signed(w_eye[i])) - 64'($signed(w_tgt[i]));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (w_adv) begin
            r_a_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_a_diff <= n_a_diff;
            r_a_side <= '{eye: w_eye, hup: w_hup, view: '0};
        end
    end

    // Unit view vector.
    logic           w_n1_valid;
    lav_pkg::t_vec3 w_n1_unit;
    lav_pkg::t_side w_n1_side;

    lav_norm u_norm_view (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_valid (r_a_valid),
        .i_vec   (r_a_diff),
        .i_side  (r_a_side),
        .o_valid (w_n1_valid),
        .o_unit  (w_n1_unit),
        .o_side  (w_n1_side)
    );

    // Hint up cross view gives the unnormalized right vector; the view joins the side data.
    lav_pkg::t_side  w_c1_side_in;
    logic            w_c1_valid;
    lav_pkg::t_wvec3 w_c1_vec;
    lav_pkg::t_side  w_c1_side;

    assign w_c1_side_in = '{eye: w_n1_side.eye, hup: w_n1_side.hup, view: w_n1_unit};

    lav_cross u_cross_right (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_valid (w_n1_valid),
        .i_a     (w_n1_side.hup),
        .i_b     (w_n1_unit),
        .i_side  (w_c1_side_in),
        .o_valid (w_c1_valid),
        .o_vec   (w_c1_vec),
        .o_side  (w_c1_side)
    );

    // Unit right vector. A hint that is zero, or whose cross product with the view is zero, yields a zero vector.
    logic           w_n2_valid;
    lav_pkg::t_vec3 w_n2_unit;
    lav_pkg::t_side w_n2_side;

    lav_norm u_norm_right (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_valid (w_c1_valid),
        .i_vec   (w_c1_vec),
        .i_side  (w_c1_side),
        .o_valid (w_n2_valid),
        .o_unit  (w_n2_unit),
        .o_side  (w_n2_side)
    );

    // View cross right gives the true up vector in Q4.60. The hint is no longer needed,
    // so its slot in the side data carries the right vector from here on.
    lav_pkg::t_side  w_c2_side_in;
    logic            w_c2_valid;
    lav_pkg::t_wvec3 w_c2_vec;
    lav_pkg::t_side  w_c2_side;

    assign w_c2_side_in = '{eye: w_n2_side.eye, hup: w_n2_unit, view: w_n2_side.view};

    lav_cross u_cross_up (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_valid (w_n2_valid),
        .i_a     (w_n2_side.view),
        .i_b     (w_n2_unit),
        .i_side  (w_c2_side_in),
        .o_valid (w_c2_valid),
        .o_vec   (w_c2_vec),
        .o_side  (w_c2_side)
    );

    // Round the true up vector back to Q2.30, half away from zero.
    logic           r_r_valid;
    lav_pkg::t_rows r_r_rows;
    lav_pkg::t_vec3 r_r_eye;
    lav_pkg::t_vec3 n_r_up;
    logic [2:0][63:0] w_up_mag;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_up_mag[i] = lav_pkg::f_round_mag(w_c2_vec[i]);
            if (w_c2_vec[i][63]) begin
                n_r_up[i] = -(w_up_mag[i][31:0]);
            end else begin
                n_r_up[i] = w_up_mag[i][31:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_r_valid <= 1'b0;
        end else if (w_adv) begin
            r_r_valid <= w_c2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_r_rows[0] <= w_c2_side.hup;
            r_r_rows[1] <= n_r_up;
            r_r_rows[2] <= w_c2_side.view;
            r_r_eye     <= w_c2_side.eye;
        end
    end

    // Translations. The last stage of this unit is the output register.
    lav_pkg::t_rows w_rows;
    lav_pkg::t_vec3 w_shift;

    lav_dot u_dot (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_valid (r_r_valid),
        .i_rows  (r_r_rows),
        .i_eye   (r_r_eye),
        .o_valid (o_valid),
        .o_rows  (w_rows),
        .o_shift (w_shift)
    );

    assign o_right_x     = w_rows[0][0];
    assign o_right_y     = w_rows[0][1];
    assign o_right_z     = w_rows[0][2];
    assign o_right_shift = w_shift[0];
    assign o_true_up_x   = w_rows[1][0];
    assign o_true_up_y   = w_rows[1][1];
    assign o_true_up_z   = w_rows[1][2];
    assign o_up_shift    = w_shift[1];
    assign o_view_x      = w_rows[2][0];
    assign o_view_y      = w_rows[2][1];
    assign o_view_z      = w_rows[2][2];
    assign o_view_shift  = w_shift[2];

    // A normalized entry never exceeds one in magnitude; a divider slip would break this.
    a_unit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ($signed(o_view_x) <= 32'sd1073741824 &&
                     $signed(o_view_x) >= -32'sd1073741824 &&
                     $signed(o_right_x) <= 32'sd1073741824 &&
                     $signed(o_right_x) >= -32'sd1073741824))
        else $error("unit vector entry out of range");

    // A zero view vector must leave right and true up at zero as well.
    a_zero_view: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_view_x == 32'd0 && o_view_y == 32'd0 && o_view_z == 32'd0) |->
        (o_right_x == 32'd0 && o_right_y == 32'd0 && o_right_z == 32'd0 &&
         o_true_up_x == 32'd0 && o_true_up_y == 32'd0 && o_true_up_z == 32'd0))
        else $error("zero view did not give zero right and up rows");

    // Reset empties the pipeline.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output beat valid right after reset");

endmodule

`default_nettype wire

/* design/lav_norm.sv */
// Vector normalizer: scaling, sum of squares, bit-serial square root and division pipelines.
`default_nettype none

module lav_norm (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  lav_pkg::t_wvec3 i_vec,
    input  lav_pkg::t_side  i_side,
    output logic            o_valid,
    output lav_pkg::t_vec3  o_unit,
    output lav_pkg::t_side  o_side
);
    localparam int unsigned SQ = lav_pkg::SQRT_STEPS;
    localparam int unsigned DV = lav_pkg::DIV_STEPS;

    // Stage 1: magnitudes and their maximum.
    logic                  r_s1_valid;
    logic [2:0][63:0]      r_s1_mag;
    logic [2:0]            r_s1_neg;
    logic [63:0]           r_s1_max;
    lav_pkg::t_side        r_s1_side;
    logic [2:0][63:0]      n_s1_mag;
    logic [63:0]           n_s1_max;

    always_comb begin
        n_s1_max = '0;
        for (int i = 0; i < 3; i++) begin
            n_s1_mag[i] = lav_pkg::f_abs64(i_vec[i]);
            if (n_s1_mag[i] > n_s1_max) begin
                n_s1_max = n_s1_mag[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_en) begin
            r_s1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1_mag  <= n_s1_mag;
            r_s1_neg  <= {i_vec[2][63], i_vec[1][63], i_vec[0][63]};
            r_s1_max  <= n_s1_max;
            r_s1_side <= i_side;
        end
    end

    // Stage 2: shift so that the largest magnitude lies in [2^30, 2^31).
    logic                  r_s2_valid;
    logic [2:0][30:0]      r_s2_m;
    logic [2:0]            r_s2_neg;
    logic                  r_s2_zero;
    lav_pkg::t_side        r_s2_side;
    logic [6:0]            s2_len;
    logic [2:0][30:0]      n_s2_m;

    always_comb begin
        s2_len = '0;
        for (int k = 0; k < 64; k++) begin
            if (r_s1_max[k]) begin
                s2_len = 7'(k + 1);
            end
        end
        for (int i = 0; i < 3; i++) begin
            if (s2_len > 7'd31) begin
                n_s2_m[i] = 31'(r_s1_mag[i] >> (s2_len - 7'd31));
            end else begin
                n_s2_m[i] = 31'(r_s1_mag[i] << (7'd31 - s2_len));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (i_en) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s2_m    <= n_s2_m;
            r_s2_neg  <= r_s1_neg;
            r_s2_zero <= (r_s1_max == 64'd0);
            r_s2_side <= r_s1_side;
        end
    end

    // Stage 3: squares.
    logic                  r_s3_valid;
    logic [2:0][61:0]      r_s3_sq;
    logic [2:0][30:0]      r_s3_m;
    logic [2:0]            r_s3_neg;
    logic                  r_s3_zero;
    lav_pkg::t_side        r_s3_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid <= 1'b0;
        end else if (i_en) begin
            r_s3_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r_s3_sq[i] <= 62'(r_s2_m[i]) * 62'(r_s2_m[i]);
            end
            r_s3_m    <= r_s2_m;
            r_s3_neg  <= r_s2_neg;
            r_s3_zero <= r_s2_zero;
            r_s3_side <= r_s2_side;
        end
    end

    // Stage 4: sum of squares.
    logic                  r_s4_valid;
    logic [63:0]           r_s4_sum;
    logic [2:0][30:0]      r_s4_m;
    logic [2:0]            r_s4_neg;
    logic                  r_s4_zero;
    lav_pkg::t_side        r_s4_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_valid <= 1'b0;
        end else if (i_en) begin
            r_s4_valid <= r_s3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s4_sum  <= 64'(r_s3_sq[0]) + 64'(r_s3_sq[1]) + 64'(r_s3_sq[2]);
            r_s4_m    <= r_s3_m;
            r_s4_neg  <= r_s3_neg;
            r_s4_zero <= r_s3_zero;
            r_s4_side <= r_s3_side;
        end
    end

    // Square root, one result bit per stage.
    logic                  r_sq_valid [SQ];
    logic [63:0]           r_sq_x     [SQ];
    logic [63:0]           r_sq_r     [SQ];
    logic [2:0][30:0]      r_sq_m     [SQ];
    logic [2:0]            r_sq_neg   [SQ];
    logic                  r_sq_zero  [SQ];
    lav_pkg::t_side        r_sq_side  [SQ];

    for (genvar k = 0; k < SQ; k++) begin : g_sqrt
        logic             v_in;
        logic [63:0]      x_in;
        logic [63:0]      r_in;
        logic [2:0][30:0] m_in;
        logic [2:0]       neg_in;
        logic             zero_in;
        lav_pkg::t_side   side_in;
        logic [63:0]      bit_w;
        logic [63:0]      trial;
        logic [63:0]      n_x;
        logic [63:0]      n_r;

        if (k == 0) begin : g_first
            assign v_in    = r_s4_valid;
            assign x_in    = r_s4_sum;
            assign r_in    = '0;
            assign m_in    = r_s4_m;
            assign neg_in  = r_s4_neg;
            assign zero_in = r_s4_zero;
            assign side_in = r_s4_side;
        end else begin : g_next
            assign v_in    = r_sq_valid[k-1];
            assign x_in    = r_sq_x[k-1];
            assign r_in    = r_sq_r[k-1];
            assign m_in    = r_sq_m[k-1];
            assign neg_in  = r_sq_neg[k-1];
            assign zero_in = r_sq_zero[k-1];
            assign side_in = r_sq_side[k-1];
        end

        assign bit_w = 64'd1 << (62 - 2 * k);
        assign trial = r_in + bit_w;

        always_comb begin
            if (x_in >= trial) begin
                n_x = x_in - trial;
                n_r = (r_in >> 1) + bit_w;
            end else begin
                n_x = x_in;
                n_r = r_in >> 1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sq_valid[k] <= 1'b0;
            end else if (i_en) begin
                r_sq_valid[k] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_sq_x[k]    <= n_x;
                r_sq_r[k]    <= n_r;
                r_sq_m[k]    <= m_in;
                r_sq_neg[k]  <= neg_in;
                r_sq_zero[k] <= zero_in;
                r_sq_side[k] <= side_in;
            end
        end
    end

    // Restoring division of each scaled magnitude by the root, one quotient bit per stage.
    logic                  r_dv_valid [DV];
    logic [31:0]           r_dv_n     [DV];
    logic [2:0][63:0]      r_dv_rem   [DV];
    logic [2:0][30:0]      r_dv_q     [DV];
    logic [2:0]            r_dv_neg   [DV];
    logic                  r_dv_zero  [DV];
    lav_pkg::t_side        r_dv_side  [DV];

    for (genvar j = 0; j < DV; j++) begin : g_div
        logic             v_in;
        logic [31:0]      n_in;
        logic [2:0][63:0] rem_in;
        logic [2:0][30:0] q_in;
        logic [2:0]       neg_in;
        logic             zero_in;
        lav_pkg::t_side   side_in;
        logic [63:0]      dvs;
        logic [2:0][63:0] n_rem;
        logic [2:0][30:0] n_q;

        if (j == 0) begin : g_first
            assign v_in    = r_sq_valid[SQ-1];
            assign n_in    = r_sq_r[SQ-1][31:0];
            assign q_in    = '0;
            assign neg_in  = r_sq_neg[SQ-1];
            assign zero_in = r_sq_zero[SQ-1];
            assign side_in = r_sq_side[SQ-1];
            for (genvar i = 0; i < 3; i++) begin : g_lane
                assign rem_in[i] = 64'(r_sq_m[SQ-1][i]) << lav_pkg::UNIT_FRAC;
            end
        end else begin : g_next
            assign v_in    = r_dv_valid[j-1];
            assign n_in    = r_dv_n[j-1];
            assign rem_in  = r_dv_rem[j-1];
            assign q_in    = r_dv_q[j-1];
            assign neg_in  = r_dv_neg[j-1];
            assign zero_in = r_dv_zero[j-1];
            assign side_in = r_dv_side[j-1];
        end

        assign dvs = 64'(n_in) << (DV - 1 - j);

        always_comb begin
            n_rem = rem_in;
            n_q   = q_in;
            for (int i = 0; i < 3; i++) begin
                if (rem_in[i] >= dvs) begin
                    n_rem[i]           = rem_in[i] - dvs;
                    n_q[i][DV - 1 - j] = 1'b1;
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_valid[j] <= 1'b0;
            end else if (i_en) begin
                r_dv_valid[j] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_dv_n[j]    <= n_in;
                r_dv_rem[j]  <= n_rem;
                r_dv_q[j]    <= n_q;
                r_dv_neg[j]  <= neg_in;
                r_dv_zero[j] <= zero_in;
                r_dv_side[j] <= side_in;
            end
        end
    end

    // Final stage: restore the signs; a zero-length vector gives zero.
    logic                  r_out_valid;
    lav_pkg::t_vec3        r_out_unit;
    lav_pkg::t_side        r_out_side;
    lav_pkg::t_vec3        n_out_unit;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (r_dv_zero[DV-1]) begin
                n_out_unit[i] = '0;
            end else if (r_dv_neg[DV-1][i]) begin
                n_out_unit[i] = -(32'(r_dv_q[DV-1][i]));
            end else begin
                n_out_unit[i] = 32'(r_dv_q[DV-1][i]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_en) begin
            r_out_valid <= r_dv_valid[DV-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_out_unit <= n_out_unit;
            r_out_side <= r_dv_side[DV-1];
        end
    end

    assign o_valid = r_out_valid;
    assign o_unit  = r_out_unit;
    assign o_side  = r_out_side;

endmodule

`default_nettype wire

/* design/lav_cross.sv */
// Two-stage cross product: registered partial products, then registered differences.
`default_nettype none

module lav_cross (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  lav_pkg::t_vec3  i_a,
    input  lav_pkg::t_vec3  i_b,
    input  lav_pkg::t_side  i_side,
    output logic            o_valid,
    output lav_pkg::t_wvec3 o_vec,
    output lav_pkg::t_side  o_side
);
    logic             r_p_valid;
    logic [5:0][63:0] r_p_prod;
    lav_pkg::t_side   r_p_side;
    logic             r_c_valid;
    lav_pkg::t_wvec3  r_c_vec;
    lav_pkg::t_side   r_c_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
            r_c_valid <= 1'b0;
        end else if (i_en) begin
            r_p_valid <= i_valid;
            r_c_valid <= r_p_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p_prod[0] <= 64'($signed(i_a[1])) * 64'($signed(i_b[2]));
            r_p_prod[1] <= 64'($signed(i_a[2])) * 64'($signed(i_b[1]));
            r_p_prod[2] <= 64'($signed(i_a[2])) * 64'($signed(i_b[0]));
            r_p_prod[3] <= 64'($signed(i_a[0])) * 64'($signed(i_b[2]));
            r_p_prod[4] <= 64'($signed(i_a[0])) * 64'($signed(i_b[1]));
            r_p_prod[5] <= 64'($signed(i_a[1])) * 64'($signed(i_b[0]));
            r_p_side    <= i_side;
            r_c_vec[0]  <= r_p_prod[0] - r_p_prod[1];
            r_c_vec[1]  <= r_p_prod[2] - r_p_prod[3];
            r_c_vec[2]  <= r_p_prod[4] - r_p_prod[5];
            r_c_side    <= r_p_side;
        end
    end

    assign o_valid = r_c_valid;
    assign o_vec   = r_c_vec;
    assign o_side  = r_c_side;

endmodule

`default_nettype wire

/* design/lav_dot.sv */
// Translation column: three dot products with the eye, negated, rounded and saturated.
`default_nettype none

module lav_dot (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_valid,
    input  lav_pkg::t_rows i_rows,
    input  lav_pkg::t_vec3 i_eye,
    output logic           o_valid,
    output lav_pkg::t_rows o_rows,
    output lav_pkg::t_vec3 o_shift
);
    logic                  r_p_valid;
    logic [2:0][2:0][63:0] r_p_prod;
    lav_pkg::t_rows        r_p_rows;
    logic                  r_s_valid;
    logic [2:0][63:0]      r_s_sum;
    lav_pkg::t_rows        r_s_rows;
    logic                  r_o_valid;
    lav_pkg::t_rows        r_o_rows;
    lav_pkg::t_vec3        r_o_shift;
    logic [2:0][63:0]      s_neg;
    logic [2:0][63:0]      s_mag;
    lav_pkg::t_vec3        n_o_shift;

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            s_neg[r] = -r_s_sum[r];
            s_mag[r] = lav_pkg::f_round_mag(s_neg[r]);
            if (s_neg[r][63]) begin
                if (s_mag[r] > 64'h0000_0000_8000_0000) begin
                    n_o_shift[r] = 32'h8000_0000;
                end else begin
                    n_o_shift[r] = -(s_mag[r][31:0]);
                end
            end else begin
                if (s_mag[r] > 64'h0000_0000_7FFF_FFFF) begin
                    n_o_shift[r] = 32'h7FFF_FFFF;
                end else begin
                    n_o_shift[r] = s_mag[r][31:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
            r_s_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else if (i_en) begin
            r_p_valid <= i_valid;
            r_s_valid <= r_p_valid;
            r_o_valid <= r_s_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    r_p_prod[r][c] <= 64'($signed(i_rows[r][c])) * 64'($signed(i_eye[c]));
                end
                r_s_sum[r] <= r_p_prod[r][0] + r_p_prod[r][1] + r_p_prod[r][2];
            end
            r_p_rows  <= i_rows;
            r_s_rows  <= r_p_rows;
            r_o_rows  <= r_s_rows;
            r_o_shift <= n_o_shift;
        end
    end

    assign o_valid = r_o_valid;
    assign o_rows  = r_o_rows;
    assign o_shift = r_o_shift;

endmodule

`default_nettype wire

/* verif/tb.sv */
// Self-checking testbench for the look-at view matrix pipeline.
`timescale 1ns / 100ps
`default_nettype none

// Expected view matrix rows, with the scoreboard that holds and checks them.
class view_matrix_board;
    typedef logic [11:0][31:0] t_mat;

    t_mat pending_rows[$];
    int   n_errors;

    function new();
        n_errors = 0;
    endfunction

    // Magnitude of a signed 64-bit value.
    static function logic [63:0] mag(input longint v);
        return v < 0 ? 64'(-v) : 64'(v);
    endfunction

    // Integer square root by the bit-by-bit method.
    static function logic [63:0] int_sqrt(input logic [63:0] x);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b = b >> 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // Scale to a unit vector in Q2.30; a zero vector stays zero.
    static function void to_unit(input longint v[3], output longint u[3]);
        logic [63:0] m[3];
        logic [63:0] top;
        logic [63:0] sq;
        logic [63:0] n;
        logic [63:0] q;
        int len;
        top = 0;
        sq = 0;
        len = 0;
        for (int i = 0; i < 3; i++) begin
            m[i] = mag(v[i]);
            if (m[i] > top) top = m[i];
        end
        if (top == 0) begin
            for (int i = 0; i < 3; i++) u[i] = 0;
            return;
        end
        while (len < 64 && (top >> len) != 0) len++;
        for (int i = 0; i < 3; i++) begin
            if (len > 31) m[i] = m[i] >> (len - 31);
            else m[i] = m[i] << (31 - len);
            sq = sq + m[i] * m[i];
        end
        n = int_sqrt(sq);
        for (int i = 0; i < 3; i++) begin
            q = (m[i] << 30) / n;
            u[i] = v[i] < 0 ? -longint'(q) : longint'(q);
        end
    endfunction

    // Drop 30 fraction bits, rounding half away from zero.
    static function longint round30(input longint v);
        logic [63:0] m;
        m = (mag(v) + (64'd1 << 29)) >> 30;
        return v < 0 ? -longint'(m) : longint'(m);
    endfunction

    // Translation of one row: minus the dot product with the eye, saturated.
    static function logic [31:0] row_shift(input longint u[3], input longint e[3]);
        longint d;
        d = round30(-(u[0] * e[0] + u[1] * e[1] + u[2] * e[2]));
        if (d > 64'sd2147483647) d = 64'sd2147483647;
        if (d < -64'sd2147483648) d = -64'sd2147483648;
        return d[31:0];
    endfunction

    function void note_beat(input logic [8:0][31:0] pts, input logic lh);
        longint eye[3];
        longint tgt[3];
        longint hup[3];
        longint dir[3];
        longint view[3];
        longint rc[3];
        longint right[3];
        longint up[3];
        t_mat m;
        for (int i = 0; i < 3; i++) begin
            eye[i] = longint'(signed'(pts[i]));
            tgt[i] = longint'(signed'(pts[3 + i]));
            hup[i] = longint'(signed'(pts[6 + i]));
            dir[i] = lh ? tgt[i] - eye[i] : eye[i] - tgt[i];
        end
        to_unit(dir, view);
        rc[0] = hup[1] * view[2] - hup[2] * view[1];
        rc[1] = hup[2] * view[0] - hup[0] * view[2];
        rc[2] = hup[0] * view[1] - hup[1] * view[0];
        to_unit(rc, right);
        up[0] = round30(view[1] * right[2] - view[2] * right[1]);
        up[1] = round30(view[2] * right[0] - view[0] * right[2]);
        up[2] = round30(view[0] * right[1] - view[1] * right[0]);
        for (int i = 0; i < 3; i++) begin
            m[i] = right[i][31:0];
            m[4 + i] = up[i][31:0];
            m[8 + i] = view[i][31:0];
        end
        m[3] = row_shift(right, eye);
        m[7] = row_shift(up, eye);
        m[11] = row_shift(view, eye);
        pending_rows.push_back(m);
    endfunction

    function void check_beat(input t_mat got);
        t_mat want;
        if (pending_rows.size() == 0) begin
            $display("%0t: unexpected output beat %h", $time, got);
            n_errors++;
            return;
        end
        want = pending_rows.pop_front();
        for (int i = 0; i < 12; i++) begin
            if (want[i] !== got[i]) begin
                $display("%0t: entry %0d expected %h actual %h", $time, i, want[i], got[i]);
                n_errors++;
            end
        end
    endfunction
endclass

module tb;
    localparam int LATENCY = 145;
    localparam longint CYCLE_LIMIT = 400000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_stall;
    logic [31:0] i_eye_x = '0, i_eye_y = '0, i_eye_z = '0;
    logic [31:0] i_target_x = '0, i_target_y = '0, i_target_z = '0;
    logic [31:0] i_hint_up_x = '0, i_hint_up_y = '0, i_hint_up_z = '0;
    logic i_left_handed = 1'b0;
    logic o_valid;
    logic i_stall = 1'b0;
    logic [31:0] o_right_x, o_right_y, o_right_z, o_right_shift;
    logic [31:0] o_true_up_x, o_true_up_y, o_true_up_z, o_up_shift;
    logic [31:0] o_view_x, o_view_y, o_view_z, o_view_shift;

    // Idle percentages for sender and receiver; a long hold-off overrides the receiver.
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_cycles = 0;
    longint n_cycles = 0;

    view_matrix_board board = new();

    look_at_view_matrix dut (.*);

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Watchdog: the slowest correct run is far shorter than this.
    always @(posedge i_clk) begin
        n_cycles <= n_cycles + 1;
        if (n_cycles > CYCLE_LIMIT) begin
            $display("[look_at_view_matrix] ERROR");
            $finish;
        end
    end

    // Receiver: random stalls, or a long hold-off counted here while the sender keeps going.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall)
                board.check_beat({o_view_shift, o_view_z, o_view_y, o_view_x,
                                  o_up_shift, o_true_up_z, o_true_up_y, o_true_up_x,
                                  o_right_shift, o_right_z, o_right_y, o_right_x});
            if (hold_cycles > 0) begin
                hold_cycles <= hold_cycles - 1;
                i_stall <= 1'b1;
            end else begin
                i_stall <= ($urandom_range(99) < recv_idle_pct);
            end
        end
    end

    // Offer one beat and hold it until it is taken. Acceptance is noted in the scoreboard
    // from the values sampled at the accepting edge.
    task automatic send_beat(input logic [8:0][31:0] pts, input logic lh);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        {i_hint_up_z, i_hint_up_y, i_hint_up_x, i_target_z, i_target_y, i_target_x,
         i_eye_z, i_eye_y, i_eye_x} <= pts;
        i_left_handed <= lh;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        board.note_beat(pts, lh);
    endtask

    // Random 32-bit coordinate; small magnitudes are common so results stay in range.
    function automatic logic [31:0] rand_coord();
        case ($urandom_range(3))
            0: return $urandom();
            1: return 32'($signed($urandom_range(2000000)) - 1000000);
            2: return 32'($signed($urandom_range(200)) - 100) << 16;
            default: return 32'($signed($urandom_range(20)) - 10);
        endcase
    endfunction

    // The caller drops valid once the last beat is taken, so that a following call can
    // present its first beat at the same edge.
    task automatic send_random(input int n);
        logic [8:0][31:0] pts;
        for (int k = 0; k < n; k++) begin
            for (int i = 0; i < 9; i++) pts[i] = rand_coord();
            // Sometimes make eye equal target or the up hint parallel to the view.
            if ($urandom_range(19) == 0) pts[5:3] = pts[2:0];
            if ($urandom_range(19) == 0) begin
                pts[8:6] = {pts[2] - pts[5], pts[1] - pts[4], pts[0] - pts[3]};
            end
            if ($urandom_range(29) == 0) pts[8:6] = '0;
            send_beat(pts, 1'($urandom()));
        end
    endtask

    localparam logic [31:0] MAXP = 32'h7fffffff;
    localparam logic [31:0] MAXN = 32'h80000000;
    localparam logic [31:0] ONE = 32'h00010000;

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed beats: axis cameras, both handedness values, degenerate vectors, extremes.
        send_beat({32'h0, ONE, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, ONE}, 1'b0);
        send_beat({32'h0, ONE, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, ONE}, 1'b1);
        send_beat({32'h0, ONE, 32'h0, ONE, ONE, ONE, ONE, ONE, ONE}, 1'b0);   // eye == target
        send_beat({32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, ONE, 32'h0, 32'h0}, 1'b0);
        send_beat({32'h0, 32'h0, ONE, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, ONE}, 1'b1);
        send_beat({MAXP, MAXP, MAXP, MAXN, MAXN, MAXN, MAXP, MAXP, MAXP}, 1'b0);
        send_beat({MAXN, MAXN, MAXN, MAXP, MAXP, MAXP, MAXN, MAXN, MAXN}, 1'b1);
        send_beat({MAXN, 32'h1, MAXP, MAXN, 32'h0, MAXP, MAXP, MAXN, 32'h1}, 1'b0);
        send_beat({32'h1, 32'h0, 32'h0, 32'h0, 32'h1, 32'h0, 32'h0, 32'h0, 32'h1}, 1'b1);
        send_beat({32'hffffffff, 32'hffffffff, 32'hffffffff, 32'h0, 32'h0, 32'h0,
                   MAXP, MAXN, MAXP}, 1'b0);
        send_beat({ONE, ONE, ONE, 32'h0, 32'h0, 32'h0, MAXN, MAXN, MAXN}, 1'b1);

        send_random(300);
        send_idle_pct = 47;
        send_random(250);
        send_idle_pct = 0;
        recv_idle_pct = 47;
        send_random(250);
        send_idle_pct = 19;
        recv_idle_pct = 19;
        send_random(250);
        // Long receiver hold-off so the pipeline fills and pushes back on its input.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_cycles = 600;
        send_random(350);
        i_valid <= 1'b0;

        while (board.pending_rows.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 20) @(posedge i_clk);
        if (board.n_errors == 0)
            $display("[look_at_view_matrix] OK");
        else
            $display("[look_at_view_matrix] ERROR");
        $finish;
    end
endmodule

`default_nettype wire
